// ===== rtl/modbus_tcp_register_server_defines.svh =====
// assertion macros shared by the rtl
`ifndef MODBUS_TCP_REGISTER_SERVER_DEFINES_SVH
`define MODBUS_TCP_REGISTER_SERVER_DEFINES_SVH

// checks that a condition implies a consequence in the same cycle
`define MTRS_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// checks that a condition implies a consequence in the next cycle
`define MTRS_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/mtrs_pkg.sv =====
`default_nettype none
package mtrs_pkg;
    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_PULL  = 2'd1,
        OP_ABORT = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    localparam logic [7:0] FC_READ_HOLD  = 8'h03;
    localparam logic [7:0] FC_READ_INPUT = 8'h04;
    localparam logic [7:0] FC_WRITE_ONE  = 8'h06;
    localparam logic [7:0] FC_WRITE_MANY = 8'h10;

    localparam logic [2:0] EXC_NONE     = 3'd0;
    localparam logic [2:0] EXC_FUNCTION = 3'd1;
    localparam logic [2:0] EXC_ADDRESS  = 3'd2;
    localparam logic [2:0] EXC_VALUE    = 3'd3;
    localparam logic [2:0] EXC_COUNT    = 3'd4;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] request_byte;
    } req_item_t;

    typedef struct packed {
        logic [7:0] response_byte;
        logic       response_valid;
        logic       response_last;
    } rsp_item_t;
endpackage
`default_nettype wire

// ===== rtl/mtrs_stream_if.sv =====
`default_nettype none
interface mtrs_stream_if #(
    parameter int W = 10
);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/mtrs_reg_file.sv =====
`default_nettype none
module mtrs_reg_file #(
    parameter int NUM_REGS = 256,
    parameter int AW = 8
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [15:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic      [15:0]   rdata
);
    logic [15:0]         mem [NUM_REGS];
    logic [NUM_REGS-1:0] vld_reg;
    logic [15:0]         mem_q_reg;
    logic [15:0]         byp_data_reg;
    logic                byp_reg;
    logic                rvld_reg;

    // valid bits stand in for the reset clear
    // read data is registered; a write to the read address is forwarded
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            rvld_reg <= 1'b0;
            byp_reg <= 1'b0;
            byp_data_reg <= '0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            rvld_reg <= vld_reg[raddr];
            byp_reg <= we && (waddr == raddr);
            byp_data_reg <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg <= mem[raddr];
    end

    assign rdata = byp_reg ? byp_data_reg : (rvld_reg ? mem_q_reg : 16'd0);
endmodule
`default_nettype wire

// ===== rtl/modbus_tcp_register_server.sv =====
// Modbus TCP register server. One item enters per cycle (op + byte) unless the output
// register holds an unaccepted item: op 0 pushes a request byte, op 1 pulls one response
// byte, op 2 drops a partial frame. A pull gives a result item in the next cycle through an
// output register, and a push that completes a frame makes its response available to the
// very next pull. The register file of NUM_REGS 16-bit entries reads as zero after reset,
// without a clearing pass. Pushes made while a response is pending are ignored.
`default_nettype none
`include "modbus_tcp_register_server_defines.svh"
module modbus_tcp_register_server #(
    parameter int NUM_REGS        = 256,
    parameter int MAX_READ_COUNT  = 126,
    parameter int MAX_FRAME_BYTES = 260
) (
    input wire logic clk,
    input wire logic rst_n,
    mtrs_stream_if.sink   req,
    mtrs_stream_if.source rsp
);
    import mtrs_pkg::*;

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    req_item_t   in_item;
    logic        in_acc;
    logic [15:0] tid_reg, pid_reg, flen_reg, start_reg, count_reg;
    logic [7:0]  unit_reg, fc_reg, vhi_reg;
    logic [8:0]  rqpos_reg, rspos_reg;
    logic        pend_reg;
    logic [2:0]  exc_reg;
    logic        out_vld_reg;
    rsp_item_t   out_reg;

    logic [15:0] tid_next, pid_next, flen_next, start_next, count_next;
    logic [7:0]  unit_next, fc_next, vhi_next;
    logic [8:0]  rqpos_next, rspos_next;
    logic        pend_next;
    logic [2:0]  exc_next;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata, rdata;

    assign in_item = req.data;
    assign req.ready = !out_vld_reg || rsp.ready;
    assign in_acc = req.valid && req.ready;
    assign rsp.valid = out_vld_reg;
    assign rsp.data = out_reg;

    mtrs_reg_file #(.NUM_REGS(NUM_REGS), .AW(AW)) u_regs (
        .clk(clk), .rst_n(rst_n), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    function automatic logic [2:0] multi_check(input logic [15:0] bc, input logic [15:0] cnt,
                                               input logic [15:0] st);
        if ({1'b0, bc} != {cnt, 1'b0})
            return EXC_COUNT;
        if ({1'b0, st} + {1'b0, cnt} > 17'(NUM_REGS))
            return EXC_ADDRESS;
        return EXC_NONE;
    endfunction

    // response byte selection
    logic [9:0]  rlen;
    logic [15:0] lfield;
    logic [7:0]  rbyte;
    logic [8:0]  k9, k9_next;
    logic [16:0] ridx, ridx_next;
    assign k9 = rspos_reg - 9'd9;
    assign ridx = {1'b0, start_reg} + 17'(k9[8:1]);

    // register file is addressed from the next response position, so its registered read data matches the current one
    assign k9_next = rspos_next - 9'd9;
    assign ridx_next = {1'b0, start_next} + 17'(k9_next[8:1]);
    assign raddr = AW'(ridx_next);

    // request parser
    logic        is_rd;
    logic [9:0]  p1, fend;
    logic [8:0]  d;
    logic [7:0]  b;
    logic [16:0] widx;
    assign b = in_item.request_byte;
    assign d = rqpos_reg - 9'd13;
    assign widx = {1'b0, start_reg} + 17'(d[8:1]);

    always_comb
    begin
        tid_next = tid_reg; pid_next = pid_reg; flen_next = flen_reg;
        start_next = start_reg; count_next = count_reg; unit_next = unit_reg;
        fc_next = fc_reg; vhi_next = vhi_reg; rqpos_next = rqpos_reg;
        rspos_next = rspos_reg; pend_next = pend_reg; exc_next = exc_reg;
        we = 1'b0; waddr = AW'(widx); wdata = {vhi_reg, b};
        p1 = {1'b0, rqpos_reg} + 10'd1;
        fend = 10'd8;
        is_rd = (fc_reg == FC_READ_HOLD) || (fc_reg == FC_READ_INPUT);
        if (in_acc && in_item.op == OP_PUSH && !pend_reg)
        begin
            case (rqpos_reg)
                9'd0:
                begin
                    tid_next = {b, 8'd0}; start_next = '0; count_next = '0;
                    exc_next = EXC_NONE; fc_next = '0;
                end
                9'd1: tid_next = {tid_reg[15:8], b};
                9'd2: pid_next = {b, 8'd0};
                9'd3: pid_next = {pid_reg[15:8], b};
                9'd4: flen_next = {b, 8'd0};
                9'd5: flen_next = {flen_reg[15:8], b};
                9'd6: unit_next = b;
                9'd7: fc_next = b;
                9'd8: start_next = {b, 8'd0};
                9'd9: start_next = {start_reg[15:8], b};
                9'd10: count_next = {b, 8'd0};
                9'd11: count_next = {count_reg[15:8], b};
                9'd12:
                begin
                    if (fc_reg == FC_WRITE_MANY)
                        exc_next = multi_check({8'd0, b}, count_reg, start_reg);
                end
                default:
                begin
                    if (fc_reg == FC_WRITE_MANY && exc_reg == EXC_NONE
                        && {8'd0, d[8:1]} < count_reg)
                    begin
                        if (!d[0])
                            vhi_next = b;
                        else if (widx < 17'(NUM_REGS))
                            we = 1'b1;
                    end
                end
            endcase
            rqpos_next = p1[8:0];
            if (p1 >= 10'd8)
            begin
                if (flen_next >= 16'd2)
                begin
                    if ({1'b0, flen_next} + 17'd6 > 17'(MAX_FRAME_BYTES))
                        fend = 10'(MAX_FRAME_BYTES);
                    else
                        fend = flen_next[9:0] + 10'd6;
                end
                if (p1 >= fend)
                begin
                    rqpos_next = '0;
                    if (flen_next >= 16'd2)
                    begin
                        pend_next = 1'b1;
                        rspos_next = '0;
                        if (fc_next == FC_READ_HOLD || fc_next == FC_READ_INPUT)
                        begin
                            if (count_next > 16'(MAX_READ_COUNT))
                                exc_next = EXC_VALUE;
                            else if ({1'b0, start_next} + {1'b0, count_next}
                                     > 17'(NUM_REGS))
                                exc_next = EXC_ADDRESS;
                        end
                        else if (fc_next == FC_WRITE_ONE)
                        begin
                            if ({1'b0, start_next} >= 17'(NUM_REGS))
                                exc_next = EXC_ADDRESS;
                            else
                            begin
                                we = 1'b1;
                                waddr = AW'(start_next);
                                wdata = count_next;
                            end
                        end
                        else if (fc_next == FC_WRITE_MANY)
                        begin
                            if (p1 <= 10'd12)
                                exc_next = multi_check(16'd0, count_next, start_next);
                        end
                        else
                            exc_next = EXC_FUNCTION;
                    end
                end
            end
        end
        else if (in_acc && in_item.op == OP_ABORT)
        begin
            rqpos_next = '0;
        end
        else if (in_acc && in_item.op == OP_PULL && pend_reg)
        begin
            if ({1'b0, rspos_reg} + 10'd1 >= rlen)
            begin
                pend_next = 1'b0;
                rspos_next = '0;
            end
            else
                rspos_next = rspos_reg + 9'd1;
        end
    end

    always_comb
    begin
        if (exc_reg != EXC_NONE)
        begin
            rlen = 10'd9; lfield = 16'd3;
        end
        else if (is_rd)
        begin
            rlen = 10'd9 + {count_reg[8:0], 1'b0};
            lfield = 16'd3 + {count_reg[14:0], 1'b0};
        end
        else
        begin
            rlen = 10'd12; lfield = 16'd6;
        end
        case (rspos_reg)
            9'd0: rbyte = tid_reg[15:8];
            9'd1: rbyte = tid_reg[7:0];
            9'd2: rbyte = pid_reg[15:8];
            9'd3: rbyte = pid_reg[7:0];
            9'd4: rbyte = lfield[15:8];
            9'd5: rbyte = lfield[7:0];
            9'd6: rbyte = unit_reg;
            9'd7: rbyte = (exc_reg != EXC_NONE) ? (fc_reg | 8'h80) : fc_reg;
            default:
            begin
                if (exc_reg != EXC_NONE)
                    rbyte = {5'd0, exc_reg};
                else if (is_rd)
                begin
                    if (rspos_reg == 9'd8)
                        rbyte = {count_reg[6:0], 1'b0};
                    else if (ridx >= 17'(NUM_REGS))
                        rbyte = 8'd0;
                    else
                        rbyte = k9[0] ? rdata[7:0] : rdata[15:8];
                end
                else
                begin
                    case (rspos_reg)
                        9'd8: rbyte = start_reg[15:8];
                        9'd9: rbyte = start_reg[7:0];
                        9'd10: rbyte = count_reg[15:8];
                        default: rbyte = count_reg[7:0];
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tid_reg <= '0; pid_reg <= '0; flen_reg <= '0; start_reg <= '0;
            count_reg <= '0; unit_reg <= '0; fc_reg <= '0; vhi_reg <= '0;
            rqpos_reg <= '0; rspos_reg <= '0; pend_reg <= 1'b0; exc_reg <= EXC_NONE;
            out_vld_reg <= 1'b0;
            out_reg <= '0;
        end
        else
        begin
            tid_reg <= tid_next; pid_reg <= pid_next; flen_reg <= flen_next;
            start_reg <= start_next; count_reg <= count_next; unit_reg <= unit_next;
            fc_reg <= fc_next; vhi_reg <= vhi_next; rqpos_reg <= rqpos_next;
            rspos_reg <= rspos_next; pend_reg <= pend_next; exc_reg <= exc_next;
            if (in_acc && in_item.op == OP_PULL)
            begin
                out_vld_reg <= 1'b1;
                out_reg.response_byte <= pend_reg ? rbyte : 8'd0;
                out_reg.response_valid <= pend_reg;
                out_reg.response_last <= pend_reg && ({1'b0, rspos_reg} + 10'd1 >= rlen);
            end
            else if (rsp.ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    `MTRS_ASSERT_NEXT(a_pull_gives_item, clk, rst_n, in_acc && in_item.op == OP_PULL,
        out_vld_reg, "pull did not produce an item")
    `MTRS_ASSERT_IMP(a_last_ends_pending, clk, rst_n, out_vld_reg && out_reg.response_last,
        out_reg.response_valid, "last byte without valid response")
    `MTRS_ASSERT_NEXT(a_push_ignored, clk, rst_n,
        pend_reg && !(in_acc && in_item.op == OP_PULL) && !(in_acc && in_item.op == OP_ABORT),
        $stable(rqpos_reg) && pend_reg, "request state moved while pending")
endmodule
`default_nettype wire
